// File: sv/ostok_pkg.sv
package ostok_pkg;

  // value byte limit: at most VALUE_BUFFER-1 bytes are passed on per value
  localparam int VALUE_BUFFER = 128;
  localparam int CNT_W        = $clog2(VALUE_BUFFER);

  // request queue between front and back
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] KEY_SPACES = 32'h2020_2020;
  localparam logic [7:0]  CHAR_NUL   = 8'h00;

  // byte classes
  typedef enum logic [2:0] {
    CL_WORD,
    CL_EQUALS,
    CL_DELIM,
    CL_QUOTE,
    CL_BSLASH,
    CL_OTHER
  } char_class_t;

  // result event codes
  typedef enum logic [2:0] {
    EV_FLAG  = 3'd0,
    EV_KEY   = 3'd1,
    EV_BYTE  = 3'd2,
    EV_END   = 3'd3,
    EV_ABORT = 3'd4
  } event_t;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic [7:0]  ch;
    logic [7:0]  key_ch;
    char_class_t cls;
    logic        nul;
  } item_t;

endpackage

// File: sv/ostok_front.sv
module ostok_front (
  input  logic [7:0]     char_in,
  output ostok_pkg::item_t item
);
  import ostok_pkg::*;

  char_class_t cls;

  // byte class lookup
  always_comb begin
    if (char_in inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h5F, 8'h7F}) begin
      cls = CL_WORD;
    end else if (char_in inside {8'h3D, 8'h3A}) begin
      cls = CL_EQUALS;
    end else if (char_in inside {8'h00, 8'h20, [8'h09:8'h0D], 8'h2C, 8'h3B, 8'h40}) begin
      cls = CL_DELIM;
    end else if (char_in == 8'h22) begin
      cls = CL_QUOTE;
    end else if (char_in == 8'h5C) begin
      cls = CL_BSLASH;
    end else begin
      cls = CL_OTHER;
    end
  end

  // upper-case copy for the key and end-of-string mark
  always_comb begin
    item.ch  = char_in;
    item.cls = cls;
    item.nul = (char_in == CHAR_NUL);
    if (char_in inside {[8'h61:8'h7A]}) begin
      item.key_ch = char_in - 8'h20;
    end else begin
      item.key_ch = char_in;
    end
  end

endmodule

// File: sv/ostok_queue.sv
module ostok_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ostok_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output ostok_pkg::item_t pop_item
);
  import ostok_pkg::*;

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/ostok_back.sv
module ostok_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  ostok_pkg::item_t item,
  output logic             item_take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       event_kind,
  output logic [31:0]      key_code,
  output logic [7:0]       value_byte
);
  import ostok_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_KEY1 = 4'd1,
    ST_KEY2 = 4'd2,
    ST_KEY3 = 4'd3,
    ST_KEY4 = 4'd4,
    ST_VAL  = 4'd5,
    ST_VESC = 4'd6,
    ST_QUO  = 4'd7,
    ST_QESC = 4'd8
  } state_t;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(VALUE_BUFFER - 1);

  state_t           state, state_next;
  logic [31:0]      key_chars, key_next;
  logic [CNT_W-1:0] value_count, count_next;
  logic             emit;
  event_t           kind;
  logic [7:0]       vbyte;
  logic             room;

  // take a request whenever the output register is free or draining
  assign item_take = item_valid && (!out_valid || out_ready);
  assign room      = (value_count < CNT_MAX);

  // next state and event for the request at the head of the queue
  always_comb begin
    state_next = state;
    key_next   = key_chars;
    count_next = value_count;
    emit       = 1'b0;
    kind       = EV_FLAG;
    vbyte      = 8'h00;
    case (state)
      ST_KEY1, ST_KEY2, ST_KEY3, ST_KEY4: begin
        if (item.cls == CL_WORD) begin
          case (state)
            ST_KEY1: begin
              key_next[23:16] = item.key_ch;
              state_next      = ST_KEY2;
            end
            ST_KEY2: begin
              key_next[15:8] = item.key_ch;
              state_next     = ST_KEY3;
            end
            ST_KEY3: begin
              key_next[7:0] = item.key_ch;
              state_next    = ST_KEY4;
            end
            default: begin
              state_next = state;
            end
          endcase
        end else if (item.cls == CL_EQUALS) begin
          count_next = '0;
          state_next = ST_VAL;
          emit       = 1'b1;
          kind       = EV_KEY;
        end else begin
          state_next = ST_IDLE;
          emit       = 1'b1;
          kind       = EV_FLAG;
        end
      end
      ST_VAL: begin
        if (item.cls == CL_DELIM) begin
          state_next = ST_IDLE;
          emit       = 1'b1;
          kind       = EV_END;
        end else if (item.cls == CL_QUOTE) begin
          state_next = ST_QUO;
        end else if (item.cls == CL_BSLASH) begin
          state_next = ST_VESC;
        end else if (room) begin
          count_next = value_count + 1'b1;
          emit       = 1'b1;
          kind       = EV_BYTE;
          vbyte      = item.ch;
        end
      end
      ST_VESC, ST_QUO, ST_QESC: begin
        if (item.nul) begin
          emit = 1'b1;
          kind = EV_ABORT;
        end else if (state == ST_VESC || state == ST_QESC) begin
          state_next = (state == ST_VESC) ? ST_VAL : ST_QUO;
          if (room) begin
            count_next = value_count + 1'b1;
            emit       = 1'b1;
            kind       = EV_BYTE;
            vbyte      = item.ch;
          end
        end else if (item.cls == CL_QUOTE) begin
          state_next = ST_VAL;
        end else if (item.cls == CL_BSLASH) begin
          state_next = ST_QESC;
        end else if (room) begin
          count_next = value_count + 1'b1;
          emit       = 1'b1;
          kind       = EV_BYTE;
          vbyte      = item.ch;
        end
      end
      default: begin
        // idle and unused codes
        if (item.cls == CL_WORD) begin
          key_next   = {item.key_ch, KEY_SPACES[23:0]};
          state_next = ST_KEY1;
        end else begin
          state_next = ST_IDLE;
        end
      end
    endcase
    // end of string returns everything to reset values
    if (item.nul) begin
      state_next = ST_IDLE;
      key_next   = KEY_SPACES;
      count_next = '0;
    end
  end

  // parser state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      key_chars   <= KEY_SPACES;
      value_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (item_take) begin
        state       <= state_next;
        key_chars   <= key_next;
        value_count <= count_next;
      end
      if (item_take && emit) begin
        out_valid  <= 1'b1;
        event_kind <= kind;
        key_code   <= key_chars;
        value_byte <= vbyte;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/option_string_tokenizer_unit.sv
// path: an accepted request is first written into the queue, then the parser step
//   puts any event that it yields into the output register
// throughput: one byte per cycle while the queue is not full; the parser takes one queued request per cycle
//   whenever its output register is empty or being taken
// reset (rst, synchronous): parser idle, key all spaces, value count zero,
//   queue empty, no event pending
module option_string_tokenizer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [31:0] key_code,
  output logic [7:0]  value_byte
);
  import ostok_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // classify incoming bytes
  ostok_front u_front (
    .char_in (char_in),
    .item    (front_item)
  );

  // decouple front and back
  ostok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (head_item)
  );

  // parser and result register
  ostok_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (!q_empty),
    .item       (head_item),
    .item_take  (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .key_code   (key_code),
    .value_byte (value_byte)
  );

endmodule

// File: sv/ostok_checker.sv
module ostok_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [31:0] key_code,
  input logic [7:0]  value_byte
);
  import ostok_pkg::*;

  // a stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(key_code)
      && $stable(value_byte))
    else $error("event changed while stalled");

  // only defined event codes
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind <= EV_ABORT)
    else $error("undefined event code");

  // value byte is zero outside byte events, and never zero in them
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_kind == EV_BYTE) == (value_byte != 8'h00)))
    else $error("value byte inconsistent with event");

  // every event carries a started key
  a_key_first: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_code[31:24] != 8'h20 && key_code[31:24] != 8'h00)
    else $error("event without key");

endmodule

bind option_string_tokenizer_unit ostok_checker u_ostok_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .event_kind (event_kind),
  .key_code   (key_code),
  .value_byte (value_byte)
);

// File: tb/option_string_tokenizer_unit_test.sv
module option_string_tokenizer_unit_test;
  import ostok_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int ITEMS_PER_PHASE  = 160;
  localparam int HOLD_CYCLES      = 80;
  localparam int LONG_VALUE_LEN   = 135;

  // parser states of the predictor
  localparam logic [3:0] PS_IDLE       = 4'd0;
  localparam logic [3:0] PS_KEY1       = 4'd1;
  localparam logic [3:0] PS_KEY4       = 4'd4;
  localparam logic [3:0] PS_VALUE      = 4'd5;
  localparam logic [3:0] PS_VALUE_ESC  = 4'd6;
  localparam logic [3:0] PS_QUOTED     = 4'd7;
  localparam logic [3:0] PS_QUOTED_ESC = 4'd8;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef struct packed {
    event_t      kind;
    logic [31:0] key;
    logic [7:0]  vbyte;
  } tok_event_t;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    tok_event_t ev;
  } stim_row_t;

  localparam tok_event_t NO_EVENT = '{EV_FLAG, 32'h0, 8'h00};

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_kind;
  logic [31:0] key_code;
  logic [7:0]  value_byte;

  // predictor state
  logic [3:0]  tok_state = PS_IDLE;
  logic [31:0] tok_key   = KEY_SPACES;
  logic [7:0]  tok_count = 8'd0;

  tok_event_t expected_events[$];
  tok_event_t exp_ev;
  stim_row_t  stim_rows[$];

  int errors = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;

  option_string_tokenizer_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_kind (event_kind),
    .key_code   (key_code),
    .value_byte (value_byte)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // value byte, dropped once the value is full
  function automatic bit keep_value_byte(input logic [7:0] c, inout tok_event_t ev);
    if (tok_count < VALUE_BUFFER - 1) begin
      tok_count = tok_count + 8'd1;
      ev.kind = EV_BYTE;
      ev.vbyte = c;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one step of the tokenizer; returns 1 when the byte yields an event
  function automatic bit tokenize_char(input logic [7:0] c, output tok_event_t ev);
    char_class_t cls;
    bit produced;
    produced = 1'b0;
    ev = NO_EVENT;

    // byte class
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h7F)
      cls = CL_WORD;
    else if (c == CH_EQUALS || c == CH_COLON)
      cls = CL_EQUALS;
    else if (c == CHAR_NUL || c == 8'h20 || (c >= 8'h09 && c <= 8'h0D) ||
             c == 8'h2C || c == 8'h3B || c == 8'h40)
      cls = CL_DELIM;
    else if (c == CH_QUOTE)
      cls = CL_QUOTE;
    else if (c == CH_BSLASH)
      cls = CL_BSLASH;
    else
      cls = CL_OTHER;

    if (tok_state >= PS_KEY1 && tok_state <= PS_KEY4) begin
      // building the key
      if (cls == CL_WORD) begin
        if (tok_state < PS_KEY4) begin
          tok_key[31 - 8 * tok_state -: 8] =
            (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
          tok_state = tok_state + 4'd1;
        end
      end else if (cls == CL_EQUALS) begin
        tok_count = 8'd0;
        tok_state = PS_VALUE;
        ev.kind = EV_KEY;
        produced = 1'b1;
      end else begin
        tok_state = PS_IDLE;
        ev.kind = EV_FLAG;
        produced = 1'b1;
      end
    end else if (tok_state == PS_VALUE) begin
      // plain value
      if (cls == CL_DELIM) begin
        tok_state = PS_IDLE;
        ev.kind = EV_END;
        produced = 1'b1;
      end else if (cls == CL_QUOTE) begin
        tok_state = PS_QUOTED;
      end else if (cls == CL_BSLASH) begin
        tok_state = PS_VALUE_ESC;
      end else begin
        produced = keep_value_byte(c, ev);
      end
    end else if (tok_state == PS_VALUE_ESC || tok_state == PS_QUOTED ||
                 tok_state == PS_QUOTED_ESC) begin
      // escaped or quoted value, abandoned at end of string
      if (c == CHAR_NUL) begin
        ev.kind = EV_ABORT;
        produced = 1'b1;
      end else if (tok_state == PS_VALUE_ESC) begin
        produced = keep_value_byte(c, ev);
        tok_state = PS_VALUE;
      end else if (tok_state == PS_QUOTED_ESC) begin
        produced = keep_value_byte(c, ev);
        tok_state = PS_QUOTED;
      end else if (cls == CL_QUOTE) begin
        tok_state = PS_VALUE;
      end else if (cls == CL_BSLASH) begin
        tok_state = PS_QUOTED_ESC;
      end else begin
        produced = keep_value_byte(c, ev);
      end
    end else begin
      // idle: a word byte opens a key
      if (cls == CL_WORD) begin
        tok_key = {((c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c), KEY_SPACES[23:0]};
        tok_state = PS_KEY1;
      end else begin
        tok_state = PS_IDLE;
      end
    end

    ev.key = tok_key;
    if (c == CHAR_NUL) begin
      tok_state = PS_IDLE;
      tok_key = KEY_SPACES;
      tok_count = 8'd0;
    end
    return produced;
  endfunction

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(63);
    if (r < 26) return 8'(8'h41 + r);
    if (r < 52) return 8'(8'h61 + (r - 26));
    if (r < 62) return 8'(8'h30 + (r - 52));
    if (r == 62) return 8'h5F;
    return 8'h7F;
  endfunction

  function automatic logic [7:0] delim_char();
    case ($urandom_range(4))
      0: return 8'h20;
      1: return 8'($urandom_range(8'h09, 8'h0D));
      2: return 8'h2C;
      3: return 8'h3B;
      default: return 8'h40;
    endcase
  endfunction

  // offer one request, predict it and wait for the handshake
  task automatic send_char(input logic [7:0] c, input bit typed, input tok_event_t typed_ev);
    int gaps;
    bit produced;
    tok_event_t ev;
    gaps = 0;
    while ($urandom_range(99) < send_idle_pct) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    produced = tokenize_char(c, ev);
    if (typed) expected_events.push_back(typed_ev);
    else if (produced) expected_events.push_back(ev);
    in_valid <= 1'b1;
    char_in <= c;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // one key, then a flag ending or a value; long_len forces a plain long value
  task automatic send_option(input int long_len);
    int val_len;
    int r;
    logic [7:0] c;
    repeat ($urandom_range(1, 6)) send_char(word_char(), 1'b0, NO_EVENT);
    if (long_len == 0 && $urandom_range(99) < 30) begin
      case ($urandom_range(3))
        0: c = CHAR_NUL;
        1: c = CH_QUOTE;
        2: c = 8'($urandom_range(255));
        default: c = delim_char();
      endcase
      send_char(c, 1'b0, NO_EVENT);
    end else begin
      send_char($urandom_range(1) ? CH_EQUALS : CH_COLON, 1'b0, NO_EVENT);
      val_len = (long_len != 0) ? long_len : $urandom_range(0, 12);
      repeat (val_len) begin
        r = $urandom_range(99);
        if (long_len != 0 || r >= 40) c = word_char();
        else if (r < 12) c = CH_QUOTE;
        else if (r < 20) c = CH_BSLASH;
        else c = 8'($urandom_range(1, 255));
        send_char(c, 1'b0, NO_EVENT);
      end
      send_char(($urandom_range(3) == 0) ? CHAR_NUL : delim_char(), 1'b0, NO_EVENT);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_events.size() != 0);
  endtask

  task automatic plain_row(input logic [7:0] c);
    stim_row_t row;
    row.ch = c;
    row.typed = 1'b0;
    row.ev = NO_EVENT;
    stim_rows.push_back(row);
  endtask

  task automatic typed_row(input logic [7:0] c, input event_t kind, input logic [31:0] key,
                           input logic [7:0] vbyte);
    stim_row_t row;
    row.ch = c;
    row.typed = 1'b1;
    row.ev = '{kind, key, vbyte};
    stim_rows.push_back(row);
  endtask

  // event checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected event: expected none, got kind %0d key %h byte %h",
                   $time, event_kind, key_code, value_byte);
        end else begin
          exp_ev = expected_events.pop_front();
          if (event_kind !== exp_ev.kind) begin
            errors++;
            $display("%0t: event_kind: expected %0d, got %0d", $time, exp_ev.kind, event_kind);
          end
          if (key_code !== exp_ev.key) begin
            errors++;
            $display("%0t: key_code: expected %h, got %h", $time, exp_ev.key, key_code);
          end
          if (value_byte !== exp_ev.vbyte) begin
            errors++;
            $display("%0t: value_byte: expected %h, got %h", $time, exp_ev.vbyte, value_byte);
          end
        end
      end
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // directed requests: extremes, every event, escapes, quotes and string ends
    plain_row(CHAR_NUL);
    plain_row(8'h61);
    plain_row(8'h62);
    plain_row(8'h5F);
    plain_row(8'h7F);
    plain_row(8'h7A);
    typed_row(8'h2C, EV_FLAG, 32'h4142_5F7F, 8'h00);
    plain_row(8'hFF);
    plain_row(8'h6B);
    typed_row(CH_EQUALS, EV_KEY, 32'h4B20_2020, 8'h00);
    typed_row(8'hFF, EV_BYTE, 32'h4B20_2020, 8'hFF);
    plain_row(CH_QUOTE);
    plain_row(8'h20);
    plain_row(CH_BSLASH);
    plain_row(CH_QUOTE);
    plain_row(CH_QUOTE);
    plain_row(CH_BSLASH);
    typed_row(CHAR_NUL, EV_ABORT, 32'h4B20_2020, 8'h00);
    plain_row(8'h39);
    plain_row(CH_COLON);
    plain_row(8'h78);
    typed_row(CHAR_NUL, EV_END, 32'h3920_2020, 8'h00);
    plain_row(8'h51);
    typed_row(CH_QUOTE, EV_FLAG, 32'h5120_2020, 8'h00);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 26;
    recv_idle_pct = 74;
    foreach (stim_rows[i]) send_char(stim_rows[i].ch, stim_rows[i].typed, stim_rows[i].ev);

    // random phases: receiver-heavy gaps, sender-heavy gaps, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 26 : 0;
      if (phase == 2) begin
        // receiver holds off while a long value keeps coming
        hold_trigger++;
        send_option(LONG_VALUE_LEN);
      end
      while (items_sent < stim_rows.size() + ITEMS_PER_PHASE * (phase + 1)) begin
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)), 1'b0, NO_EVENT);
        end else begin
          send_option(0);
        end
      end
      pause_until_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
